[src/ihq_pkg.sv]
package ihq_pkg;
  localparam int HeapDepth = 256;
  localparam int ClientCount = 256;
  localparam int PrioW = 16;
  localparam int SlotW = $clog2(HeapDepth);
  localparam int CountW = SlotW + 1;
  localparam int ClientW = 8;
  localparam int DishW = 16;
  localparam int EntryW = ClientW + DishW + PrioW;
  localparam int MapW = CountW;

  localparam logic [1:0] MODE_INSERT  = 2'd0;
  localparam logic [1:0] MODE_EXTRACT = 2'd1;
  localparam logic [1:0] MODE_CHANGE  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_SLOT  = 2'd3;

  typedef struct packed {
    logic [ClientW-1:0] client;
    logic [DishW-1:0] dish;
    logic signed [PrioW-1:0] prio;
  } entry_t;

  // saturate a 17-bit sum to the priority range
  function automatic logic signed [PrioW-1:0] sat_prio(input logic signed [PrioW:0] v);
    logic signed [PrioW-1:0] r;
    begin
      if (v[PrioW] != v[PrioW-1]) begin
        r = v[PrioW] ? {1'b1, {(PrioW-1){1'b0}}} : {1'b0, {(PrioW-1){1'b1}}};
      end else begin
        r = v[PrioW-1:0];
      end
      return r;
    end
  endfunction
endpackage

[src/ihq_ram.sv]
module ihq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];

  // one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/indexed_max_heap_queue_top.sv]
// Indexed max-heap queue of orders (client, dish tag, signed priority).
// Input channel: raise start with in_mode and the in_ fields while busy is
// low; the beat is taken on that edge and busy rises the next cycle.
// Modes: insert, extract maximum, change priority at a heap slot.
// Result channel: exactly one result beat per command, shown for one cycle
// with out_valid high; the receiver cannot stall and must take it then.
// Latency: the result beat shows in the cycle right after busy falls, and a
// new command may be taken at the edge that ends that cycle. An error or
// undefined mode goes straight to the done state. A command that touches
// the heap keeps busy while it climbs or sinks level by level, a change
// sinking at most from the root through 8 levels with 256 slots. Each
// level needs separate reads of the heap memory's single read port (parent
// or two children) and writes of the swapped pair and of the position map.
// Reset (rst_n low, synchronous): count goes to zero, then a clearing pass
// writes absent into all 256 position map entries, one per cycle; busy stays
// high until that pass ends. Heap memory contents are not cleared.
module indexed_max_heap_queue_top (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [1:0] in_mode,
  input  logic [ihq_pkg::ClientW-1:0] in_client_id,
  input  logic [ihq_pkg::DishW-1:0] in_dish_tag,
  input  logic signed [ihq_pkg::PrioW-1:0] in_priority_req,
  input  logic [7:0] in_heap_slot,
  input  logic signed [15:0] in_delta,
  output logic out_valid,
  output logic [1:0] out_status,
  output logic [ihq_pkg::ClientW-1:0] out_client,
  output logic [ihq_pkg::DishW-1:0] out_dish,
  output logic signed [ihq_pkg::PrioW-1:0] out_priority,
  output logic signed [ihq_pkg::MapW-1:0] out_client_slot,
  output logic [ihq_pkg::CountW-1:0] out_entry_count
);
  import ihq_pkg::*;

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_INS   = 5'd2;
  localparam logic [4:0] S_EXR   = 5'd3;
  localparam logic [4:0] S_EXW   = 5'd4;
  localparam logic [4:0] S_CHR   = 5'd5;
  localparam logic [4:0] S_CHW   = 5'd6;
  localparam logic [4:0] S_UPR   = 5'd7;
  localparam logic [4:0] S_UPC   = 5'd8;
  localparam logic [4:0] S_DNL   = 5'd9;
  localparam logic [4:0] S_DNR   = 5'd10;
  localparam logic [4:0] S_DNC   = 5'd11;
  localparam logic [4:0] S_SWB   = 5'd12;
  localparam logic [4:0] S_MAPA  = 5'd13;
  localparam logic [4:0] S_MAPR  = 5'd14;
  localparam logic [4:0] S_MAPW  = 5'd15;
  localparam logic [4:0] S_DONE  = 5'd16;
  localparam logic [4:0] S_EXL   = 5'd17;
  localparam logic [4:0] S_DNW   = 5'd18;

  logic [4:0] state_r, state_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [SlotW-1:0] clr_r, clr_nxt;
  logic [SlotW-1:0] k_r, k_nxt;     // current slot of the moving entry
  logic [SlotW-1:0] o_r, o_nxt;     // other slot (parent or child)
  entry_t cur_r, cur_nxt;           // moving entry
  entry_t oth_r, oth_nxt;           // other entry
  entry_t tch_r, tch_nxt;           // touched entry for the result
  logic up_r, up_nxt;               // sift direction
  logic [1:0] st_r, st_nxt;
  logic [1:0] res_r, res_nxt;       // result kind: 0 fixed, 1 map lookup

  // heap memory port
  logic h_we;
  logic [SlotW-1:0] h_wa, h_ra;
  entry_t h_wd, h_rd;
  // position map memory port
  logic m_we;
  logic [7:0] m_wa, m_ra;
  logic [MapW-1:0] m_wd, m_rd;

  ihq_ram #(.Width(EntryW), .Depth(HeapDepth)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
  );
  ihq_ram #(.Width(MapW), .Depth(ClientCount)) u_map (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd)
  );

  logic accept;
  logic [SlotW-1:0] par_k, lch_k;
  logic [CountW:0] lch_full;
  logic signed [PrioW:0] chg_sum;
  logic [7:0] map2_a_r, map2_a_nxt;
  logic [MapW-1:0] map2_d_r, map2_d_nxt;
  logic signed [15:0] in_delta_r;

  assign accept = start && !busy;
  assign busy = (state_r != S_IDLE);
  assign par_k = SlotW'((k_r - 1'b1) >> 1);
  assign lch_full = {k_r, 1'b1} + (CountW+1)'(0);
  assign lch_k = SlotW'({k_r, 1'b1});
  assign chg_sum = {h_rd.prio[PrioW-1], h_rd.prio} + {in_delta_r[15], in_delta_r};

  always_ff @(posedge clk) begin
    if (accept) begin
      in_delta_r <= in_delta;
    end
  end

  // control sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    clr_nxt = clr_r;
    k_nxt = k_r;
    o_nxt = o_r;
    cur_nxt = cur_r;
    oth_nxt = oth_r;
    tch_nxt = tch_r;
    up_nxt = up_r;
    st_nxt = st_r;
    res_nxt = res_r;
    map2_a_nxt = map2_a_r;
    map2_d_nxt = map2_d_r;
    h_we = 1'b0;
    h_wa = k_r;
    h_wd = cur_r;
    h_ra = k_r;
    m_we = 1'b0;
    m_wa = cur_r.client;
    m_wd = MapW'(k_r);
    m_ra = tch_r.client;
    unique case (state_r)
      S_CLR: begin
        m_we = 1'b1;
        m_wa = 8'(clr_r);
        m_wd = '1;
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          st_nxt = ST_OK;
          res_nxt = 2'd0;
          tch_nxt = '0;
          case (in_mode)
            MODE_INSERT: begin
              if (count_r >= CountW'(HeapDepth)) begin
                st_nxt = ST_FULL;
                state_nxt = S_DONE;
              end else begin
                cur_nxt.client = in_client_id;
                cur_nxt.dish = in_dish_tag;
                cur_nxt.prio = in_priority_req;
                tch_nxt = cur_nxt;
                k_nxt = SlotW'(count_r);
                count_nxt = count_r + 1'b1;
                up_nxt = 1'b1;
                state_nxt = S_INS;
              end
            end
            MODE_EXTRACT: begin
              if (count_r == '0) begin
                st_nxt = ST_EMPTY;
                state_nxt = S_DONE;
              end else begin
                k_nxt = '0;
                state_nxt = S_EXR;
              end
            end
            MODE_CHANGE: begin
              if (CountW'(in_heap_slot) >= count_r) begin
                st_nxt = ST_SLOT;
                state_nxt = S_DONE;
              end else begin
                k_nxt = SlotW'(in_heap_slot);
                state_nxt = S_CHR;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_INS: begin
        // write new entry and its map slot
        h_we = 1'b1;
        m_we = 1'b1;
        res_nxt = 2'd1;
        state_nxt = S_UPR;
      end
      S_EXR: begin
        // root read issued
        state_nxt = S_EXL;
      end
      S_EXL: begin
        // root arrives; now read last
        tch_nxt = h_rd;
        h_ra = SlotW'(count_r - 1'b1);
        state_nxt = S_EXW;
      end
      S_EXW: begin
        // h_rd = last entry; move it to root and map it to slot 0; S_MAPA marks the removed client absent
        cur_nxt = h_rd;
        h_we = 1'b1;
        h_wa = '0;
        h_wd = h_rd;
        m_we = 1'b1;
        m_wa = h_rd.client;
        m_wd = '0;
        map2_a_nxt = tch_r.client;
        map2_d_nxt = '1;
        count_nxt = count_r - 1'b1;
        k_nxt = '0;
        up_nxt = 1'b0;
        res_nxt = 2'd1;
        state_nxt = S_MAPA;
      end
      S_CHR: state_nxt = S_CHW;
      S_CHW: begin
        cur_nxt = h_rd;
        cur_nxt.prio = sat_prio(chg_sum);
        tch_nxt = cur_nxt;
        h_we = 1'b1;
        h_wd = cur_nxt;
        up_nxt = (in_delta_r > 0);
        res_nxt = 2'd1;
        state_nxt = S_UPR;
      end
      S_UPR: begin
        if (up_r) begin
          if (k_r == '0) begin
            state_nxt = S_MAPR;
          end else begin
            h_ra = par_k;
            o_nxt = par_k;
            state_nxt = S_UPC;
          end
        end else begin
          if (lch_full >= (CountW+1)'(count_r)) begin
            state_nxt = S_MAPR;
          end else begin
            h_ra = lch_k;
            o_nxt = lch_k;
            state_nxt = S_DNL;
          end
        end
      end
      S_UPC: begin
        oth_nxt = h_rd;
        if (h_rd.prio < cur_r.prio) begin
          state_nxt = S_SWB;
        end else begin
          state_nxt = S_MAPR;
        end
      end
      S_DNL: begin
        oth_nxt = h_rd;
        if (lch_full + 1'b1 < (CountW+1)'(count_r)) begin
          h_ra = SlotW'(o_r + 1'b1);
          state_nxt = S_DNR;
        end else begin
          state_nxt = S_DNC;
        end
      end
      S_DNR: begin
        if (oth_r.prio < h_rd.prio) begin
          oth_nxt = h_rd;
          o_nxt = SlotW'(o_r + 1'b1);
        end
        state_nxt = S_DNC;
      end
      S_DNC: begin
        if (cur_r.prio < oth_r.prio) begin
          state_nxt = S_SWB;
        end else begin
          state_nxt = S_MAPR;
        end
      end
      S_SWB: begin
        // other entry into current slot; S_DNW then puts the moving entry into the other slot
        h_we = 1'b1;
        h_wa = k_r;
        h_wd = oth_r;
        m_we = 1'b1;
        m_wa = oth_r.client;
        m_wd = MapW'(k_r);
        state_nxt = S_DNW;
      end
      S_DNW: begin
        h_we = 1'b1;
        h_wa = o_r;
        h_wd = cur_r;
        m_we = 1'b1;
        m_wa = cur_r.client;
        m_wd = MapW'(o_r);
        k_nxt = o_r;
        state_nxt = S_UPR;
      end
      S_MAPA: begin
        // second map write of extract
        m_we = 1'b1;
        m_wa = map2_a_r;
        m_wd = map2_d_r;
        state_nxt = S_UPR;
      end
      S_MAPR: begin
        m_ra = tch_r.client;
        state_nxt = S_MAPW;
      end
      S_MAPW: begin
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [MapW-1:0] slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      count_r <= '0;
      clr_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      clr_r <= clr_nxt;
      out_valid <= (state_r == S_DONE);
    end
    k_r <= k_nxt;
    o_r <= o_nxt;
    cur_r <= cur_nxt;
    oth_r <= oth_nxt;
    tch_r <= tch_nxt;
    up_r <= up_nxt;
    st_r <= st_nxt;
    res_r <= res_nxt;
    map2_a_r <= map2_a_nxt;
    map2_d_r <= map2_d_nxt;
    if (state_r == S_MAPW) slot_r <= m_rd;
    if (state_r == S_DONE) begin
      out_status <= st_r;
      out_client <= tch_r.client;
      out_dish <= tch_r.dish;
      out_priority <= tch_r.prio;
      out_client_slot <= (res_r == 2'd1) ? slot_r : '1;
      out_entry_count <= count_r;
    end
  end

  // result beats only follow the done state
  a_valid_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_DONE) else $error("stray result beat");
  // count never exceeds the heap depth
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CountW'(HeapDepth)) else $error("count overflow");
  // busy is high whenever the sequencer is not idle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> busy) else $error("busy low while working");
endmodule

[tb/indexed_max_heap_queue_top_tb.sv]
`timescale 1ns / 100ps

module indexed_max_heap_queue_top_tb;
  import ihq_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CycleLimit = 2000000;

  typedef struct {
    logic [1:0] status;
    logic [ClientW-1:0] client;
    logic [DishW-1:0] dish;
    logic signed [PrioW-1:0] prio;
    logic signed [MapW-1:0] slot;
    logic [CountW-1:0] count;
  } order_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_mode = MODE_INSERT;
  logic [ClientW-1:0] in_client_id = '0;
  logic [DishW-1:0] in_dish_tag = '0;
  logic signed [PrioW-1:0] in_priority_req = '0;
  logic [7:0] in_heap_slot = '0;
  logic signed [15:0] in_delta = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [ClientW-1:0] out_client;
  logic [DishW-1:0] out_dish;
  logic signed [PrioW-1:0] out_priority;
  logic signed [MapW-1:0] out_client_slot;
  logic [CountW-1:0] out_entry_count;

  // shadow copy of the queue contents
  entry_t model_heap[HeapDepth];
  logic signed [MapW-1:0] model_pos[ClientCount];
  int model_count;

  order_reply_t pending_replies[$];
  int fail_count = 0;
  int cycle_count = 0;
  bit no_gaps = 1'b0;

  indexed_max_heap_queue_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_client_id(in_client_id), .in_dish_tag(in_dish_tag),
    .in_priority_req(in_priority_req), .in_heap_slot(in_heap_slot),
    .in_delta(in_delta), .out_valid(out_valid), .out_status(out_status),
    .out_client(out_client), .out_dish(out_dish), .out_priority(out_priority),
    .out_client_slot(out_client_slot), .out_entry_count(out_entry_count)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic signed [PrioW-1:0] clamp_prio(input int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[PrioW-1:0];
  endfunction

  function automatic void swap_orders(input int a, input int b);
    entry_t t;
    t = model_heap[a];
    model_heap[a] = model_heap[b];
    model_heap[b] = t;
    model_pos[model_heap[a].client] = MapW'(a);
    model_pos[model_heap[b].client] = MapW'(b);
  endfunction

  function automatic void bubble_up(input int k);
    int p;
    while (k > 0) begin
      p = (k - 1) / 2;
      if (!(model_heap[p].prio < model_heap[k].prio)) break;
      swap_orders(k, p);
      k = p;
    end
  endfunction

  function automatic void bubble_down(input int k);
    int l;
    int big;
    while (k < model_count) begin
      l = 2 * k + 1;
      if (l >= model_count) break;
      big = l;
      if (l + 1 < model_count && model_heap[l].prio < model_heap[l + 1].prio) big = l + 1;
      if (!(model_heap[k].prio < model_heap[big].prio)) break;
      swap_orders(k, big);
      k = big;
    end
  endfunction

  // work out the reply for one accepted command and update the shadow queue
  function automatic order_reply_t apply_command(input logic [1:0] mode,
      input logic [7:0] cl, input logic [15:0] dish, input logic signed [15:0] pr,
      input logic [7:0] slot, input logic signed [15:0] dl);
    order_reply_t r;
    entry_t e;
    bit touched;
    int last;
    r.status = ST_OK;
    e = '0;
    touched = 1'b0;
    case (mode)
      MODE_INSERT: begin
        if (model_count >= HeapDepth) begin
          r.status = ST_FULL;
        end else begin
          e.client = cl;
          e.dish = dish;
          e.prio = clamp_prio(int'(pr));
          model_heap[model_count] = e;
          model_pos[cl] = MapW'(model_count);
          model_count++;
          bubble_up(model_count - 1);
          touched = 1'b1;
        end
      end
      MODE_EXTRACT: begin
        if (model_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          last = model_count - 1;
          e = model_heap[0];
          model_heap[0] = model_heap[last];
          model_heap[last] = e;
          model_pos[model_heap[0].client] = '0;
          model_pos[model_heap[last].client] = '1;
          model_count--;
          bubble_down(0);
          touched = 1'b1;
        end
      end
      MODE_CHANGE: begin
        if (int'(slot) >= model_count) begin
          r.status = ST_SLOT;
        end else begin
          model_heap[slot].prio = clamp_prio(int'(model_heap[slot].prio) + int'(dl));
          e = model_heap[slot];
          if (dl > 0) bubble_up(int'(slot));
          else bubble_down(int'(slot));
          touched = 1'b1;
        end
      end
      default: ;
    endcase
    r.client = e.client;
    r.dish = e.dish;
    r.prio = e.prio;
    r.slot = touched ? model_pos[e.client] : -9'sd1;
    r.count = CountW'(model_count);
    return r;
  endfunction

  // send one command beat, wait for it to be taken, then idle for a random gap that may be zero
  task automatic send_command(input logic [1:0] mode, input logic [7:0] cl,
      input logic [15:0] dish, input logic signed [15:0] pr, input logic [7:0] slot,
      input logic signed [15:0] dl);
    int gap;
    in_mode <= mode;
    in_client_id <= cl;
    in_dish_tag <= dish;
    in_priority_req <= pr;
    in_heap_slot <= slot;
    in_delta <= dl;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_replies.push_back(apply_command(mode, cl, dish, pr, slot, dl));
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // compare every result beat with the oldest expectation
  always @(posedge clk) begin
    order_reply_t x;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result beat, actual status %0d client %0d", $time,
                 out_status, out_client);
        fail_count++;
      end else begin
        x = pending_replies.pop_front();
        if (out_status !== x.status) begin
          $display("%0t: status expected %0d actual %0d", $time, x.status, out_status);
          fail_count++;
        end
        if (out_client !== x.client) begin
          $display("%0t: client expected %0d actual %0d", $time, x.client, out_client);
          fail_count++;
        end
        if (out_dish !== x.dish) begin
          $display("%0t: dish expected %0h actual %0h", $time, x.dish, out_dish);
          fail_count++;
        end
        if (out_priority !== x.prio) begin
          $display("%0t: priority expected %0d actual %0d", $time, x.prio, out_priority);
          fail_count++;
        end
        if (out_client_slot !== x.slot) begin
          $display("%0t: client slot expected %0d actual %0d", $time, x.slot,
                   out_client_slot);
          fail_count++;
        end
        if (out_entry_count !== x.count) begin
          $display("%0t: entry count expected %0d actual %0d", $time, x.count,
                   out_entry_count);
          fail_count++;
        end
      end
    end
  end

  // errors and the undefined mode on an empty queue
  task automatic test_empty_errors();
    send_command(MODE_EXTRACT, 8'd0, 16'd0, 16'sd0, 8'd0, 16'sd0);
    send_command(MODE_CHANGE, 8'd0, 16'd0, 16'sd0, 8'd0, 16'sd5);
    send_command(MODE_CHANGE, 8'd0, 16'd0, 16'sd0, 8'd255, 16'sd5);
    send_command(MODE_UNUSED, 8'hff, 16'hffff, -16'sd1, 8'hff, -16'sd1);
  endtask

  // field extremes, saturation, zero delta, repeated client
  task automatic test_directed_orders();
    send_command(MODE_INSERT, 8'd0, 16'h0000, 16'sd32767, 8'd0, 16'sd0);
    send_command(MODE_INSERT, 8'd255, 16'hffff, -16'sd32768, 8'd0, 16'sd0);
    send_command(MODE_INSERT, 8'd17, 16'h5a5a, 16'sd0, 8'd0, 16'sd0);
    send_command(MODE_INSERT, 8'd17, 16'ha5a5, 16'sd100, 8'd0, 16'sd0);
    send_command(MODE_INSERT, 8'd42, 16'h1234, 16'sd100, 8'd0, 16'sd0);
    send_command(MODE_CHANGE, 8'd0, 16'd0, 16'sd0, 8'd0, 16'sd32767);
    send_command(MODE_CHANGE, 8'd0, 16'd0, 16'sd0, 8'd0, -16'sd32768);
    send_command(MODE_CHANGE, 8'd0, 16'd0, 16'sd0, 8'd1, 16'sd0);
    send_command(MODE_CHANGE, 8'd0, 16'd0, 16'sd0, 8'd4, -16'sd32768);
    send_command(MODE_CHANGE, 8'd0, 16'd0, 16'sd0, 8'd4, -16'sd32768);
    send_command(MODE_CHANGE, 8'd0, 16'd0, 16'sd0, 8'd2, 16'sd32767);
    send_command(MODE_CHANGE, 8'd0, 16'd0, 16'sd0, 8'd5, 16'sd1);
    send_command(MODE_UNUSED, 8'd3, 16'd3, 16'sd3, 8'd0, 16'sd3);
    repeat (6) send_command(MODE_EXTRACT, 8'd0, 16'd0, 16'sd0, 8'd0, 16'sd0);
  endtask

  // fill to the top, hit the full case, change the last and first slots, then drain and extract once more from empty
  task automatic test_fill_full();
    no_gaps = 1'b1;
    for (int i = 0; i < HeapDepth; i++)
      send_command(MODE_INSERT, i[7:0], 16'($urandom), 16'($urandom_range(0, 200)) - 16'sd100,
                   8'd0, 16'sd0);
    no_gaps = 1'b0;
    send_command(MODE_INSERT, 8'd7, 16'd7, 16'sd7, 8'd0, 16'sd0);
    send_command(MODE_CHANGE, 8'd0, 16'd0, 16'sd0, 8'd255, 16'sd32767);
    send_command(MODE_CHANGE, 8'd0, 16'd0, 16'sd0, 8'd0, -16'sd32768);
    while (model_count > 0) send_command(MODE_EXTRACT, 8'd0, 16'd0, 16'sd0, 8'd0, 16'sd0);
    send_command(MODE_EXTRACT, 8'd0, 16'd0, 16'sd0, 8'd0, 16'sd0);
  endtask

  // random traffic in phases that grow and shrink the queue
  task automatic test_random_traffic(input int n);
    int pick;
    int grow;
    logic [7:0] slot;
    logic signed [15:0] pr;
    logic signed [15:0] dl;
    grow = 60;
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) begin
        grow = $urandom_range(25, 85);
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      if (i == n / 2) wait_drained();
      pick = $urandom_range(0, 99);
      pr = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64)) - 16'sd32;
      dl = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)) - 16'sd20;
      if (model_count > 0 && $urandom_range(0, 9) != 0)
        slot = 8'($urandom_range(0, model_count - 1));
      else
        slot = 8'($urandom);
      if (pick < 2)
        send_command(MODE_UNUSED, 8'($urandom), 16'($urandom), pr, slot, dl);
      else if (pick < grow)
        send_command(MODE_INSERT, 8'($urandom), 16'($urandom), pr, slot, dl);
      else if (pick < grow + (100 - grow) / 2)
        send_command(MODE_EXTRACT, 8'($urandom), 16'($urandom), pr, slot, dl);
      else
        send_command(MODE_CHANGE, 8'($urandom), 16'($urandom), pr, slot, dl);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    model_count = 0;
    for (int i = 0; i < ClientCount; i++) model_pos[i] = '1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_errors();
    test_directed_orders();
    wait_drained();
    test_fill_full();
    test_random_traffic(1100);
    wait_drained();
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
